@@ hw/rtl/gbts_pkg.sv @@
package gbts_pkg;

  // Storage geometry
  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);
  localparam int PTR_W     = $clog2(BUF_DEPTH + 1);

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int POS_W    = 9;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;

  // Wide enough for position plus gap length
  localparam int WIDE_W = ((POS_W > PTR_W) ? POS_W : PTR_W) + 1;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_MOVE   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] OP_TRUNC  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_END   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_out;
    logic                at_end;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    cursor;
  } out_item_t;

endpackage

@@ hw/rtl/gbts_ram.sv @@
module gbts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/gap_buffer_text_store.sv @@
// Gap-buffer text store: 256-byte text memory with a movable gap.
// Input channel in_valid/in_stall/in_item carries one operation per item:
// move cursor, insert byte, read byte, truncate before cursor.
// Result channel out_valid/out_stall/out_item returns exactly one item
// per input item: byte read, end flag, status and the cursor afterward.
// Insert, truncate and read each pass from S_EXEC to S_DONE; read fetches its
// byte into the RAM output register on the way. Move alternates S_EXEC and
// S_MV_WR once per byte copied across the gap, since each copy is one RAM
// read followed by one RAM write through the single-port-pair text RAM.
// in_stall stays high until the current item's result is loaded into the
// output register, so one item is in flight at a time. Reset (rst_n low,
// synchronous) empties the text and then runs a clearing pass that writes
// zero to every memory byte, one per cycle; in_stall is high during the pass.
// When the receiver stalls, the finished result waits in the output
// register and the sequencer holds its last step until the register frees.
module gap_buffer_text_store (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gbts_pkg::out_item_t out_item
);

  import gbts_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MV_WR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Gap edges: gap_start is the cursor
  logic [PTR_W-1:0] gs_r, gs_nxt;
  logic [PTR_W-1:0] ge_r, ge_nxt;

  // Clearing pass address
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Latched item
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;

  // Per-item result bits
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                at_end_r, at_end_nxt;
  logic                rd_hit_r, rd_hit_nxt;   // char_out comes from RAM
  logic                dir_left_r, dir_left_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Text RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // Compare operands, all at one common width
  logic [WIDE_W-1:0] pos_w, gs_w, ge_w, depth_w, phys_w;
  logic              out_free;

  assign pos_w   = WIDE_W'(pos_r);
  assign gs_w    = WIDE_W'(gs_r);
  assign ge_w    = WIDE_W'(ge_r);
  assign depth_w = WIDE_W'(BUF_DEPTH);
  // logical to physical: skip the gap at and past the cursor
  assign phys_w  = (pos_w < gs_w) ? pos_w : (pos_w + (ge_w - gs_w));

  assign out_free = !out_valid_r || !out_stall;

  gbts_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUF_DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    gs_nxt        = gs_r;
    ge_nxt        = ge_r;
    clr_cnt_nxt   = clr_cnt_r;
    func_nxt      = func_r;
    pos_nxt       = pos_r;
    ch_nxt        = ch_r;
    status_nxt    = status_r;
    at_end_nxt    = at_end_r;
    rd_hit_nxt    = rd_hit_r;
    dir_left_nxt  = dir_left_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(BUF_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_item.func;
          pos_nxt    = in_item.position;
          ch_nxt     = in_item.char_in;
          status_nxt = ST_OK;
          at_end_nxt = 1'b0;
          rd_hit_nxt = 1'b0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (func_r)
          OP_MOVE: begin
            if (pos_w >= depth_w) begin
              status_nxt = ST_RANGE;
            end else if (pos_w < gs_w) begin
              // left: fetch byte just below the cursor
              ram_re       = 1'b1;
              ram_raddr    = ADDR_W'(gs_r - 1'b1);
              dir_left_nxt = 1'b1;
              state_nxt    = S_MV_WR;
            end else if (gs_w < pos_w) begin
              if (ge_w >= depth_w) begin
                // no text after the gap; earlier copies stay
                status_nxt = ST_END;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = ADDR_W'(ge_r);
                dir_left_nxt = 1'b0;
                state_nxt    = S_MV_WR;
              end
            end
          end
          OP_INSERT: begin
            if (gs_r >= ge_r || gs_w >= depth_w) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(gs_r);
              ram_wdata = ch_r;
              gs_nxt    = gs_r + 1'b1;
            end
          end
          OP_READ: begin
            if (phys_w >= depth_w) begin
              at_end_nxt = 1'b1;
            end else begin
              // data lands in the RAM output register for S_DONE
              ram_re     = 1'b1;
              ram_raddr  = ADDR_W'(phys_w);
              rd_hit_nxt = 1'b1;
            end
          end
          OP_TRUNC: begin
            if (pos_w > gs_w) begin
              status_nxt = ST_RANGE;
            end else begin
              gs_nxt = PTR_W'(pos_r);
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end

      S_MV_WR: begin
        // second half of one copy across the gap, then recheck
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (dir_left_r) begin
          ram_waddr = ADDR_W'(ge_r - 1'b1);
          gs_nxt    = gs_r - 1'b1;
          ge_nxt    = ge_r - 1'b1;
        end else begin
          ram_waddr = ADDR_W'(gs_r);
          gs_nxt    = gs_r + 1'b1;
          ge_nxt    = ge_r + 1'b1;
        end
        state_nxt = S_EXEC;
      end

      S_DONE: begin
        if (out_free) begin
          out_item_nxt.char_out = rd_hit_r ? ram_rdata : '0;
          out_item_nxt.at_end   = at_end_r;
          out_item_nxt.status   = status_r;
          out_item_nxt.cursor   = POS_W'(gs_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      gs_r        <= '0;
      ge_r        <= PTR_W'(BUF_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    pos_r      <= pos_nxt;
    ch_r       <= ch_nxt;
    status_r   <= status_nxt;
    at_end_r   <= at_end_nxt;
    rd_hit_r   <= rd_hit_nxt;
    dir_left_r <= dir_left_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
